// ===== src/hcbp_pkg.sv =====
// hcbp_pkg: shared widths, defaults and item kinds for the huffman code bit packer
// no dependencies; compile first
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int KIND_W = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int ACC_W  = 7;
  localparam int HELD_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

endpackage

`default_nettype wire

// ===== src/hcbp_in_if.sv =====
// hcbp_in_if / hcbp_out_if: valid-ready channels for input items and packed bytes
// depends on hcbp_pkg
`default_nettype none

interface hcbp_in_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_word;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, kind, symbol, code_word, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== src/hcbp_ram.sv =====
// hcbp_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/huffman_code_bit_packer_core.sv =====
// huffman_code_bit_packer_core: code table lookup and msb-first byte packing
// depends on hcbp_pkg, hcbp_in_if, hcbp_out_if, hcbp_ram
//
//   channel   role   carries
//   item      sink   kind, symbol, code_word, code_length
//   result    source out_byte, last
//
// an item passes through the table read stage and then the merge stage;
// the merge stage waits while the byte register still has bytes of an earlier item,
// so an encode giving k bytes holds later items while they drain (1 item per cycle
// when each item gives at most one byte and the output does not stall).
// synchronous reset clears the code length valid bits, accumulator and byte count;
// the table itself needs no clearing pass. output bytes load as an item leaves merge.
`default_nettype none

module huffman_code_bit_packer_core #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hcbp_in_if.sink    item,
  hcbp_out_if.source result
);
  import hcbp_pkg::*;

  localparam int AW    = $clog2(SYMBOL_COUNT);
  localparam int XW    = MAX_CODE_LEN + ACC_W;
  localparam int TW    = $clog2(XW + 1);
  localparam int NB    = XW / BYTE_W;
  localparam int BUF_W = NB * BYTE_W;
  localparam int CW    = $clog2(NB + 1);
  localparam int RW    = CODE_W + LEN_W;

  // table read stage
  logic              in_acc;
  logic              sym_ok;
  logic [LEN_W-1:0]  len_clamp;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     addr;
  logic [RW-1:0]     rd_data;
  logic [SYMBOL_COUNT-1:0] written;

  // merge stage
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic              s1_ok;
  logic              s1_written;
  logic              s1_drain;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [HELD_W-1:0] held;
  logic [HELD_W-1:0] held_next;

  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic [LEN_W-1:0]  n;
  logic [XW-1:0]     code_x;
  logic [XW-1:0]     mask_x;
  logic [XW-1:0]     v;
  logic [XW-1:0]     x;
  logic [TW-1:0]     total;
  logic [CW-1:0]     enc_cnt;
  logic [HELD_W-1:0] enc_held;
  logic [ACC_W-1:0]  enc_acc;
  logic [HELD_W-1:0] fl_sh;
  logic [BYTE_W-1:0] fl_byte;
  logic [CW-1:0]     m_cnt;
  logic [BUF_W-1:0]  m_buf;

  // byte output register
  logic [BUF_W-1:0]  pack_reg;
  logic [CW-1:0]     bytes_left;
  logic              shift_free;
  logic              out_acc;

  assign in_acc    = item.valid && item.ready;
  assign sym_ok    = {1'b0, item.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign len_clamp = (item.code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                                : item.code_length;
  assign addr      = item.symbol[AW-1:0];
  assign wr_en     = in_acc && (item.kind == KIND_LOAD) && sym_ok;
  assign rd_en     = in_acc && (item.kind == KIND_ENCODE) && sym_ok;

  hcbp_ram #(
    .WIDTH (RW),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata ({item.code_word, len_clamp}),
    .re    (rd_en),
    .raddr (addr),
    .rdata (rd_data)
  );

  // an entry never loaded reads as length zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind <= item.kind;
      s1_ok   <= sym_ok;
    end
    if (rd_en) begin
      s1_written <= written[addr];
    end
  end

  assign rd_code = rd_data[RW-1 -: CODE_W];
  assign rd_len  = rd_data[LEN_W-1:0];
  assign n       = (s1_ok && s1_written) ? rd_len : '0;

  // code bits above bit 31 read as zero
  generate
    if (XW >= CODE_W) begin : g_code_wide
      assign code_x = {{(XW - CODE_W){1'b0}}, rd_code};
    end else begin : g_code_narrow
      assign code_x = rd_code[XW-1:0];
    end
  endgenerate

  assign mask_x   = ~({XW{1'b1}} << n);
  assign v        = (XW'(acc) << n) | (code_x & mask_x);
  assign total    = TW'(held) + TW'(n);
  assign x        = v << (TW'(XW) - total);
  assign enc_cnt  = CW'(total >> 3);
  assign enc_held = total[HELD_W-1:0];
  assign enc_acc  = v[ACC_W-1:0] & ~({ACC_W{1'b1}} << enc_held);
  assign fl_sh    = HELD_W'(4'(BYTE_W) - {1'b0, held});
  assign fl_byte  = {1'b0, acc} << fl_sh;

  always_comb begin
    m_cnt     = '0;
    m_buf     = '0;
    acc_next  = acc;
    held_next = held;
    unique case (s1_kind)
      KIND_ENCODE: begin
        m_cnt     = enc_cnt;
        m_buf     = x[XW-1 -: BUF_W];
        acc_next  = enc_acc;
        held_next = enc_held;
      end
      KIND_FLUSH: begin
        if (held != '0) begin
          m_cnt     = CW'(1);
          m_buf     = BUF_W'(fl_byte) << (BUF_W - BYTE_W);
          acc_next  = '0;
          held_next = '0;
        end
      end
      default: begin
        m_cnt = '0;
      end
    endcase
  end

  assign out_acc    = result.valid && result.ready;
  assign shift_free = (bytes_left == '0) || ((bytes_left == CW'(1)) && result.ready);
  assign s1_drain   = s1_valid && ((m_cnt == '0) || shift_free);
  assign item.ready = !rst && (!s1_valid || s1_drain);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
    end else if (s1_drain) begin
      acc  <= acc_next;
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
    end else if (s1_drain && (m_cnt != '0)) begin
      bytes_left <= m_cnt;
    end else if (out_acc) begin
      bytes_left <= bytes_left - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_drain && (m_cnt != '0)) begin
      pack_reg <= m_buf;
    end else if (out_acc) begin
      pack_reg <= pack_reg << BYTE_W;
    end
  end

  assign result.valid    = bytes_left != '0;
  assign result.out_byte = pack_reg[BUF_W-1 -: BYTE_W];
  assign result.last     = bytes_left == CW'(1);

endmodule

`default_nettype wire

// ===== src/hcbp_checker.sv =====
// hcbp_checker: port level checks on the huffman code bit packer, bound to the top level
// depends on hcbp_pkg, huffman_code_bit_packer_core
`default_nettype none

module hcbp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hcbp_pkg::BYTE_W-1:0] out_byte,
  input logic                      last
);
  import hcbp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled byte transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled output byte changed");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) $fell(rst) |-> in_ready)
    else $error("input not ready after reset");

  // no output appears unless in_acc or its past value shows an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_acc && !$past(in_acc) |=> !out_valid)
    else $error("output byte without a causing transaction");

  // a burst keeps going until its last byte
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("burst ended before last byte");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_byte  (result.out_byte),
  .last      (result.last)
);

`default_nettype wire

// ===== dv/hcbp_byte_checker.sv =====
// hcbp_byte_checker: predicts the packed byte stream of the huffman code bit packer
// and compares it with the result channel; depends on hcbp_pkg, hcbp_in_if, hcbp_out_if
`timescale 1ns / 100ps

module hcbp_byte_checker #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  hcbp_in_if   item,
  hcbp_out_if  result,
  output int   mismatches,
  output int   pending,
  output int   bytes_seen
);
  import hcbp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } packed_byte_t;

  logic [CODE_W-1:0] code_tab [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_tab  [SYMBOL_COUNT];
  logic [ACC_W-1:0]  acc_bits;
  logic [HELD_W-1:0] held_bits;
  packed_byte_t      expected_bytes [$];
  int                fail_count = 0;
  int                byte_count = 0;

  // works out the bytes one transaction gives and queues them in order
  task automatic pack_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] padded;
    logic              code_bit;
    int                held;
    logic [BYTE_W-1:0] produced [$];
    packed_byte_t      entry;
    case (kind)
      KIND_LOAD: begin
        if (int'(sym) < SYMBOL_COUNT) begin
          code_tab[sym] = word;
          len_tab[sym]  = (int'(len) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len;
        end
      end
      KIND_ENCODE: begin
        if (int'(sym) < SYMBOL_COUNT) begin
          acc  = {1'b0, acc_bits};
          held = int'(held_bits);
          for (int p = int'(len_tab[sym]) - 1; p >= 0; p--) begin
            // positions above the code word read as zero
            code_bit = (p < CODE_W) ? code_tab[sym][p] : 1'b0;
            acc      = {acc[BYTE_W-2:0], code_bit};
            held++;
            if (held == BYTE_W) begin
              produced.insert(produced.size(), acc);
              acc  = '0;
              held = 0;
            end
          end
          acc_bits  = acc[ACC_W-1:0];
          held_bits = HELD_W'(held);
        end
      end
      KIND_FLUSH: begin
        if (held_bits != '0) begin
          padded = {1'b0, acc_bits};
          padded = padded << (BYTE_W - int'(held_bits));
          produced.insert(produced.size(), padded);
          acc_bits  = '0;
          held_bits = '0;
        end
      end
      default: ;
    endcase
    foreach (produced[i]) begin
      entry.out_byte = produced[i];
      entry.last     = (i == produced.size() - 1);
      expected_bytes.insert(expected_bytes.size(), entry);
    end
  endtask

  task automatic report(input string what, input packed_byte_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("%t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.out_byte, want.last, result.out_byte, result.last);
  endtask

  always @(posedge clk) begin
    packed_byte_t want;
    if (rst) begin
      foreach (len_tab[i]) len_tab[i] = '0;
      acc_bits  = '0;
      held_bits = '0;
      expected_bytes.delete();
    end else begin
      if (item.valid && item.ready)
        pack_item(item.kind, item.symbol, item.code_word, item.code_length);
      if (result.valid && result.ready) begin
        byte_count++;
        if (expected_bytes.size() == 0) begin
          report("unexpected byte", '0);
        end else begin
          want = expected_bytes.pop_front();
          if (want.out_byte !== result.out_byte)
            report("byte mismatch", want);
          else if (want.last !== result.last)
            report("last flag mismatch", want);
        end
      end
    end
    mismatches <= fail_count;
    pending    <= expected_bytes.size();
    bytes_seen <= byte_count;
  end

endmodule

// ===== dv/huffman_code_bit_packer_core_test.sv =====
// huffman_code_bit_packer_core_test: stimulus and verdict for the huffman code bit packer
// depends on hcbp_pkg, hcbp_in_if, hcbp_out_if, hcbp_byte_checker and the block itself
`timescale 1ns / 100ps

module huffman_code_bit_packer_core_test;
  import hcbp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcbp_in_if  item_ch ();
  hcbp_out_if byte_ch ();

  int mismatches;
  int pending;
  int bytes_seen;
  int items_sent = 0;
  int burst_left = 8;
  int rx_cycle = 0;
  int rx_mode = 0;
  bit sym_loaded [256];
  logic [SYM_W-1:0] loaded_syms [$];

  always #1 clk = ~clk;

  huffman_code_bit_packer_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (byte_ch)
  );

  hcbp_byte_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (byte_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .bytes_seen (bytes_seen)
  );

  // receiver: stall pattern drawn at random from four modes, redrawn periodically
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 60 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       byte_ch.ready <= 1'b1;
      1:       byte_ch.ready <= 1'($urandom_range(0, 1));
      2:       byte_ch.ready <= (rx_cycle % 4 != 0);
      default: byte_ch.ready <= (rx_cycle % 16 >= 10);
    endcase
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= kind;
    item_ch.symbol      <= sym;
    item_ch.code_word   <= word;
    item_ch.code_length <= len;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    if (kind == KIND_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.insert(loaded_syms.size(), sym);
    end
    burst_left--;
    if (burst_left <= 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
  endtask

  task automatic load_code(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] word,
                           input logic [LEN_W-1:0] len);
    send_item(KIND_LOAD, sym, word, len);
  endtask

  task automatic encode(input logic [SYM_W-1:0] sym);
    send_item(KIND_ENCODE, sym, $urandom, LEN_W'($urandom));
  endtask

  task automatic flush();
    send_item(KIND_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
  endtask

  initial begin
    int               counted;
    int               pick;
    logic [LEN_W-1:0] len;
    item_ch.valid       <= 1'b0;
    item_ch.kind        <= KIND_LOAD;
    item_ch.symbol      <= '0;
    item_ch.code_word   <= '0;
    item_ch.code_length <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty flush, zero length, clamped lengths, byte boundaries
    flush();
    load_code(8'd0,   32'hDEAD_BEEF, 6'd0);
    load_code(8'd255, 32'hFFFF_FFFF, 6'd63);
    load_code(8'd1,   32'h8000_0001, 6'd33);
    load_code(8'd2,   32'h0000_0001, 6'd1);
    load_code(8'd3,   32'h0000_0055, 6'd7);
    load_code(8'd128, 32'h0000_00A5, 6'd8);
    encode(8'd0);
    encode(8'd2);
    flush();
    encode(8'd255);
    encode(8'd3);
    encode(8'd2);
    encode(8'd3);
    encode(8'd1);
    send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    flush();
    encode(8'd128);
    load_code(8'd2, 32'h0000_0000, 6'd32);
    encode(8'd2);
    flush();

    // random: mostly encodes of loaded symbols with short codes, some loads, flushes and unused kinds
    counted = 0;
    while (counted < 100) begin
      pick = $urandom_range(0, 99);
      if (pick < 20 || (pick < 85 && loaded_syms.size() == 0)) begin
        case ($urandom_range(0, 19))
          0:       len = '0;
          1:       len = LEN_W'($urandom_range(33, 63));
          2, 3, 4: len = LEN_W'($urandom_range(9, 32));
          default: len = LEN_W'($urandom_range(1, 8));
        endcase
        load_code(SYM_W'($urandom_range(0, 255)), $urandom, len);
        counted++;
      end else if (pick < 85) begin
        encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        counted++;
      end else if (pick < 97) begin
        flush();
        counted++;
      end else begin
        send_item(KIND_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
      end
    end
    flush();
    item_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("sent %0d items (loads, encodes, flushes, unused kind), checked %0d packed bytes",
             items_sent, bytes_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0)
      $display("huffman_code_bit_packer_core_test: done, clean");
    else
      $display("huffman_code_bit_packer_core_test: done, errors");
    $finish;
  end

  initial begin
    #400_000;
    $display("timeout with %0d bytes still expected", pending);
    $display("huffman_code_bit_packer_core_test: done, errors");
    $finish;
  end

endmodule
